/* hdl/mep_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies; imported by mandelbrot_escape_pixel.
`timescale 1ns / 1ps

package mep_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int PITCH_W    = 47;
    localparam int ORIGIN_W   = 48;
    localparam int ITER_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd1024;
    localparam logic [ITER_W-1:0]   MAX_ITER_RST = 8'd100;

    // Multiply sequencer steps: issue partials 0..3, accumulate 1..4, store 5
    localparam logic [2:0] STEP_MUL_LAST = 3'd3;
    localparam logic [2:0] STEP_ACC_LAST = 3'd4;
    localparam logic [2:0] STEP_STORE    = 3'd5;

    // Jet color map: band = (2t+25)/50, divide by 50 via reciprocal multiply
    localparam logic [9:0]  JET_OFFSET = 10'd25;
    localparam logic [9:0]  JET_DIV    = 10'd50;
    localparam logic [14:0] DIV50_MUL  = 15'd20972;
    localparam int          DIV50_SH   = 20;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    localparam logic [3:0] BAND_BLUE   = 4'd0;
    localparam logic [3:0] BAND_CYAN   = 4'd1;
    localparam logic [3:0] BAND_GREEN  = 4'd2;
    localparam logic [3:0] BAND_YELLOW = 4'd3;
    localparam logic [3:0] BAND_RED    = 4'd4;

    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 32'hFF00_0000;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ITER_W-1:0]  iterations;
        logic               inside_res;
    } t_pix_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ITER,
        S_TEST,
        S_BAND,
        S_COLOR
    } t_state;

    typedef enum logic [2:0] {
        OP_CX,
        OP_CY,
        OP_XS,
        OP_YS,
        OP_XY
    } t_mul_op;

endpackage

/* hdl/mandelbrot_escape_pixel.sv */
// Mandelbrot escape-time pixel with jet color map; depends on mep_pkg.
// One shared multiplier builds every product from four partial products.
// Throughput: one pixel at a time; the next transfer is taken once the result
// sits in the output register. Reset (synchronous, active low) idles the
// sequencer, drops the pending result and restores the register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel #(
    parameter int FRAC_BITS = 44
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mep_pkg::t_pix_in  i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mep_pkg::t_pix_out o_out_data,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import mep_pkg::*;

    // Q4.FRAC_BITS coordinates
    localparam int QW      = FRAC_BITS + 4;
    // Half width of a multiplier operand: must split |z| < 2 and the pitch
    localparam int HW      = (FRAC_BITS + 2) / 2;
    localparam int MW      = (HW > 24) ? HW : 24;
    localparam int AW      = 4 * MW;
    localparam int XW      = FRAC_BITS + 2;          // square, < 4.0
    localparam int PW_P    = FRAC_BITS + 3;          // 2*x*y, < 8.0
    localparam int ROFF_W  = HEIGHT_W + 1;
    localparam int PROD_W  = HEIGHT_W + PITCH_W;     // |row offset| * pitch
    localparam int SAT_W   = (PROD_W + 2 > QW + 2) ? PROD_W + 2 : QW + 2;
    localparam logic [XW:0] FOUR = {1'b1, {XW{1'b0}}};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                     r_state, n_state;
    t_mul_op                    r_op, n_op;
    logic [2:0]                 r_step, n_step;

    logic signed [ORIGIN_W-1:0] r_origin_x, r_origin_y;
    logic [PITCH_W-1:0]         r_pitch;
    logic [HEIGHT_W-1:0]        r_height;
    logic [ITER_W-1:0]          r_max_iter;

    logic [COORD_W-1:0]         r_col, n_col;
    logic                       r_rowneg, n_rowneg;
    logic [HEIGHT_W-1:0]        r_rowmag, n_rowmag;
    logic signed [QW-1:0]       r_cx, n_cx, r_cy, n_cy;
    logic signed [QW-1:0]       r_zx, n_zx, r_zy, n_zy;
    logic [XW-1:0]              r_xs, n_xs, r_ys, n_ys;
    logic [PW_P-1:0]            r_p, n_p;
    logic [ITER_W-1:0]          r_t, n_t;
    logic                       r_inside, n_inside;
    logic [2*MW-1:0]            r_prod, n_prod;
    logic [1:0]                 r_psh, n_psh;
    logic [AW-1:0]              r_acc, n_acc;
    logic [3:0]                 r_band, n_band;
    logic [5:0]                 r_rem, n_rem;
    logic                       r_out_valid, n_out_valid;
    t_pix_out                   r_out_data, n_out_data;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [ROFF_W-1:0]          row_off, row_off_neg;
    logic [QW-1:0]              ax, ay;
    logic [2*MW-1:0]            op_a, op_b;
    logic [MW-1:0]              a_part, b_part;
    logic [AW-1:0]              acc_add;
    logic signed [PROD_W:0]     c_prod;
    logic signed [SAT_W-1:0]    cx_sum, cy_sum, zx_sum, zy_sum;
    logic signed [PW_P:0]       p_s;
    logic                       xy_neg;
    logic [XW:0]                sq_sum;
    logic [9:0]                 jet_num, jet_rem;
    logic [24:0]                band_prod;
    logic [13:0]                f_num;
    logic [28:0]                f_prod;
    logic [7:0]                 f_val, red, green, blue;

    // Clamp a wide signed sum into the Q4 range
    function automatic logic signed [QW-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-QW:0] top;
        top = v[SAT_W-1:QW-1];
        if ((&top) || !(|top)) begin
            return v[QW-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(QW-1){1'b0}}};
        end else begin
            return {1'b0, {(QW-1){1'b1}}};
        end
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Row axis flips: offset is height - row, may go negative
    assign row_off     = {1'b0, r_height} - {{(ROFF_W-COORD_W){1'b0}}, i_in_data.row};
    assign row_off_neg = -row_off;

    assign ax = r_zx[QW-1] ? -r_zx : r_zx;
    assign ay = r_zy[QW-1] ? -r_zy : r_zy;

    // Operand pair for the product being built
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_op)
            OP_CX: begin
                op_a[COORD_W-1:0]  = r_col;
                op_b[PITCH_W-1:0]  = r_pitch;
            end
            OP_CY: begin
                op_a[HEIGHT_W-1:0] = r_rowmag;
                op_b[PITCH_W-1:0]  = r_pitch;
            end
            OP_XS: begin
                op_a[FRAC_BITS:0]  = ax[FRAC_BITS:0];
                op_b[FRAC_BITS:0]  = ax[FRAC_BITS:0];
            end
            OP_YS: begin
                op_a[FRAC_BITS:0]  = ay[FRAC_BITS:0];
                op_b[FRAC_BITS:0]  = ay[FRAC_BITS:0];
            end
            OP_XY: begin
                op_a[FRAC_BITS:0]  = ax[FRAC_BITS:0];
                op_b[FRAC_BITS:0]  = ay[FRAC_BITS:0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Step bit 0 picks the half of A, bit 1 the half of B
    assign a_part = r_step[0] ? op_a[2*MW-1:MW] : op_a[MW-1:0];
    assign b_part = r_step[1] ? op_b[2*MW-1:MW] : op_b[MW-1:0];

    always_comb begin
        unique case (r_psh)
            2'b00:   acc_add = AW'(r_prod);
            2'b11:   acc_add = AW'(r_prod) << (2 * MW);
            default: acc_add = AW'(r_prod) << MW;
        endcase
    end

    // c = origin + offset * pitch, before clamping
    assign c_prod = $signed({1'b0, r_acc[PROD_W-1:0]});
    assign cx_sum = SAT_W'(r_origin_x) + SAT_W'(c_prod);
    assign cy_sum = SAT_W'(r_origin_y) + (r_rowneg ? -SAT_W'(c_prod) : SAT_W'(c_prod));

    // z update: zx = x^2 - y^2 + cx, zy = +-2|x||y| + cy
    assign xy_neg = r_zx[QW-1] ^ r_zy[QW-1];
    assign p_s    = $signed({1'b0, r_p});
    assign zx_sum = SAT_W'($signed({1'b0, r_xs})) - SAT_W'($signed({1'b0, r_ys}))
                  + SAT_W'(r_cx);
    assign zy_sum = SAT_W'(r_cy) + (xy_neg ? -SAT_W'(p_s) : SAT_W'(p_s));
    assign sq_sum = {1'b0, r_xs} + {1'b0, r_ys};

    // Color band and fraction, divide by 50 through the reciprocal
    assign jet_num   = {1'b0, r_t, 1'b0} + JET_OFFSET;
    assign band_prod = jet_num * DIV50_MUL;
    assign jet_rem   = jet_num - 10'(band_prod[DIV50_SH +: 4] * JET_DIV);
    assign f_num     = r_rem * FULL_SCALE;
    assign f_prod    = f_num * DIV50_MUL;
    assign f_val     = f_prod[DIV50_SH +: 8];

    always_comb begin
        red   = '0;
        green = '0;
        blue  = '0;
        unique case (r_band)
            BAND_BLUE: begin
                blue  = f_val;
            end
            BAND_CYAN: begin
                green = f_val;
                blue  = FULL_SCALE;
            end
            BAND_GREEN: begin
                red   = f_val;
                green = FULL_SCALE;
                blue  = FULL_SCALE - f_val;
            end
            BAND_YELLOW: begin
                red   = FULL_SCALE;
                green = FULL_SCALE - f_val;
            end
            BAND_RED: begin
                red   = FULL_SCALE - f_val;
            end
            default: begin
                red   = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath loads
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_col       = r_col;
        n_rowneg    = r_rowneg;
        n_rowmag    = r_rowmag;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_zx        = r_zx;
        n_zy        = r_zy;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_p         = r_p;
        n_t         = r_t;
        n_inside    = r_inside;
        n_prod      = r_prod;
        n_psh       = r_psh;
        n_acc       = r_acc;
        n_band      = r_band;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // drop the result once the far side takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_col    = i_in_data.column;
                    n_rowneg = row_off[ROFF_W-1];
                    n_rowmag = row_off[ROFF_W-1] ? row_off_neg[HEIGHT_W-1:0]
                                                 : row_off[HEIGHT_W-1:0];
                    n_zx     = '0;
                    n_zy     = '0;
                    n_t      = '0;
                    n_inside = 1'b1;
                    n_op     = OP_CX;
                    n_step   = '0;
                    n_state  = S_MUL;
                end
            end

            S_MUL: begin
                // issue one partial product, accumulate the previous one
                if (r_step <= STEP_MUL_LAST) begin
                    n_prod = a_part * b_part;
                    n_psh  = r_step[1:0];
                end
                if (r_step != '0 && r_step <= STEP_ACC_LAST) begin
                    n_acc = ((r_step == 3'd1) ? '0 : r_acc) + acc_add;
                end
                if (r_step == STEP_STORE) begin
                    n_step = '0;
                    unique case (r_op)
                        OP_CX: begin
                            n_cx = sat_q(cx_sum);
                            n_op = OP_CY;
                        end
                        OP_CY: begin
                            n_cy    = sat_q(cy_sum);
                            n_state = S_ITER;
                        end
                        OP_XS: begin
                            n_xs = r_acc[FRAC_BITS +: XW];
                            n_op = OP_YS;
                        end
                        OP_YS: begin
                            n_ys = r_acc[FRAC_BITS +: XW];
                            n_op = OP_XY;
                        end
                        OP_XY: begin
                            n_p     = r_acc[FRAC_BITS-1 +: PW_P];
                            n_state = S_TEST;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    n_step = r_step + 3'd1;
                end
            end

            S_ITER: begin
                // count the pass first, then escape at once on a large component
                if (r_t >= r_max_iter) begin
                    n_state = S_BAND;
                end else begin
                    n_t = r_t + 1'b1;
                    if ((|ax[QW-1:FRAC_BITS+1]) || (|ay[QW-1:FRAC_BITS+1])) begin
                        n_inside = 1'b0;
                        n_state  = S_BAND;
                    end else begin
                        n_op    = OP_XS;
                        n_step  = '0;
                        n_state = S_MUL;
                    end
                end
            end

            S_TEST: begin
                if (sq_sum >= FOUR) begin
                    n_inside = 1'b0;
                    n_state  = S_BAND;
                end else begin
                    n_zx    = sat_q(zx_sum);
                    n_zy    = sat_q(zy_sum);
                    n_state = S_ITER;
                end
            end

            S_BAND: begin
                n_band  = band_prod[DIV50_SH +: 4];
                n_rem   = jet_rem[5:0];
                n_state = S_COLOR;
            end

            S_COLOR: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_data.color           = r_inside ? COLOR_BLACK
                                                          : {ALPHA_OPAQUE, red, green, blue};
                    n_out_data.iterations      = r_t;
                    n_out_data.inside_res      = r_inside;
                    n_state                    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CX;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_pitch    <= '0;
            r_height   <= HEIGHT_RST;
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data[ORIGIN_W-1:0];
                CFG_PITCH:    r_pitch    <= i_cfg_data[PITCH_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[HEIGHT_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default:      r_max_iter <= r_max_iter;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_rowneg   <= n_rowneg;
        r_rowmag   <= n_rowmag;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_zx       <= n_zx;
        r_zy       <= n_zy;
        r_xs       <= n_xs;
        r_ys       <= n_ys;
        r_p        <= n_p;
        r_t        <= n_t;
        r_inside   <= n_inside;
        r_prod     <= n_prod;
        r_psh      <= n_psh;
        r_acc      <= n_acc;
        r_band     <= n_band;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

endmodule
